// File: rtl/bnas_pkg.sv
// Shared types, constants and the next-state function of the attractor search block.
package bnas_pkg;

  localparam int unsigned NODES       = 8;
  localparam int unsigned FANIN_MAX   = 4;
  localparam int unsigned RULE_KINDS  = 5;
  localparam int unsigned IDX_BITS    = 3;
  localparam int unsigned SLOT_BITS   = 12;
  localparam int unsigned STATE_W     = 8;
  localparam int unsigned STEP_W      = 9;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned NODE_CNT_W  = 4;
  localparam int unsigned FANIN_CNT_W = 3;
  localparam int unsigned WIRING_W    = 48;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned STORE_DEPTH = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT  = 2'd0,
    CFG_FANIN_COUNT = 2'd1,
    CFG_WIRING_LOW  = 2'd2,
    CFG_WIRING_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_READ   = 2'd2,
    ST_FINISH = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } stat_t;

  // Applies the synchronous rule once; n and k are already clamped to their legal ranges.
  function automatic logic [STATE_W-1:0] next_state(
    input logic [STATE_W-1:0]       x,
    input logic [NODE_CNT_W-1:0]    n,
    input logic [FANIN_CNT_W-1:0]   k,
    input logic [2*WIRING_W-1:0]    wiring
  );
    logic [STATE_W-1:0]  r;
    logic                v;
    logic                y;
    logic [IDX_BITS-1:0] w;
    r = '0;
    for (int i = 0; i < NODES; i++) begin
      w = wiring[i*SLOT_BITS +: IDX_BITS];
      v = x[w];
      for (int s = 1; s < FANIN_MAX; s++) begin
        w = wiring[i*SLOT_BITS + s*IDX_BITS +: IDX_BITS];
        y = x[w];
        if (s < int'(k)) begin
          case (i % RULE_KINDS)
            0:       v = v | y;
            1:       v = !v && !y;
            2:       v = !v || !y;
            3:       v = v & y;
            default: v = !v && !y;
          endcase
        end
      end
      if (i < int'(n)) begin
        r[i] = v;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/boolean_network_attractor_search.sv
// Top level of the Boolean network attractor search block.
//
//   Channel   Signals                                   Direction
//   config    cfg_we_i, cfg_index_i, cfg_data_i         in, write only
//   request   in_valid_i/in_ready_o, start_state_i      in
//   result    out_valid_o/out_ready_i, six result ports out
//
// A request makes one next-state evaluation and one visit-map lookup per cycle until a
// visited state repeats, then a registered read of the visit memory; its result is
// registered once the output register is free.
// Reset clears control state and the visit bits; the visit memory needs no clearing pass.
// A finished result waits in the output register while a new request may be accepted.
module boolean_network_attractor_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bnas_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bnas_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bnas_pkg::STATE_W-1:0]     start_state_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bnas_pkg::STEP_W-1:0]      steps_to_repeat_o,
  output logic [bnas_pkg::STATE_W-1:0]     cycle_start_o,
  output logic [bnas_pkg::STEP_W-1:0]      cycle_length_o,
  output logic [bnas_pkg::STATE_W-1:0]     step_added_o,
  output logic [bnas_pkg::TOTAL_W-1:0]     total_steps_o,
  output logic [bnas_pkg::TOTAL_W-1:0]     run_count_o
);

  bnas_pkg::ctl_t  ctl;
  bnas_pkg::stat_t stat;

  bnas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  bnas_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_state_i    (start_state_i),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .steps_to_repeat_o(steps_to_repeat_o),
    .cycle_start_o    (cycle_start_o),
    .cycle_length_o   (cycle_length_o),
    .step_added_o     (step_added_o),
    .total_steps_o    (total_steps_o),
    .run_count_o      (run_count_o)
  );

endmodule

// File: rtl/bnas_ram.sv
// Generic single-write, single-read memory with registered read data.
module bnas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bnas_ctrl.sv
// Sequencing state machine of the attractor search block.
module bnas_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bnas_pkg::stat_t stat_i,
  output bnas_pkg::ctl_t  ctl_o
);

  bnas_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bnas_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bnas_pkg::ST_RUN;
      end
      bnas_pkg::ST_RUN: begin
        if (stat_i.hit) state_d = bnas_pkg::ST_READ;
      end
      bnas_pkg::ST_READ: begin
        state_d = bnas_pkg::ST_FINISH;
      end
      bnas_pkg::ST_FINISH: begin
        if (stat_i.out_free) state_d = bnas_pkg::ST_IDLE;
      end
      default: state_d = bnas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctl_o         = '0;
    unique case (state_q)
      bnas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      bnas_pkg::ST_RUN: begin
        ctl_o.step = 1'b1;
      end
      bnas_pkg::ST_READ: begin
        ctl_o.capture = 1'b1;
      end
      bnas_pkg::ST_FINISH: begin
        ctl_o.finish = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bnas_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/bnas_dp.sv
// Datapath: configuration registers, next-state logic, visit map and result registers.
module bnas_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bnas_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bnas_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [bnas_pkg::STATE_W-1:0]        start_state_i,
  input  bnas_pkg::ctl_t                      ctl_i,
  output bnas_pkg::stat_t                     stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bnas_pkg::STEP_W-1:0]         steps_to_repeat_o,
  output logic [bnas_pkg::STATE_W-1:0]        cycle_start_o,
  output logic [bnas_pkg::STEP_W-1:0]         cycle_length_o,
  output logic [bnas_pkg::STATE_W-1:0]        step_added_o,
  output logic [bnas_pkg::TOTAL_W-1:0]        total_steps_o,
  output logic [bnas_pkg::TOTAL_W-1:0]        run_count_o
);

  localparam int unsigned SW = bnas_pkg::STATE_W;
  localparam int unsigned JW = bnas_pkg::STEP_W;
  localparam int unsigned TW = bnas_pkg::TOTAL_W;

  logic [bnas_pkg::NODE_CNT_W-1:0]  node_count_q;
  logic [bnas_pkg::FANIN_CNT_W-1:0] fanin_count_q;
  logic [bnas_pkg::WIRING_W-1:0]    wiring_low_q;
  logic [bnas_pkg::WIRING_W-1:0]    wiring_high_q;

  logic [bnas_pkg::NODE_CNT_W-1:0]  n_eff;
  logic [bnas_pkg::FANIN_CNT_W-1:0] k_eff;
  logic [SW-1:0]                    mask;
  logic [SW-1:0]                    start_masked;
  logic [SW-1:0]                    nx;
  logic [JW-1:0]                    j_next;
  logic                             hit;

  logic [SW-1:0]                    state_q, state_d;
  logic [JW-1:0]                    step_q, step_d;
  logic [bnas_pkg::STORE_DEPTH-1:0] visited_q, visited_d;
  logic [SW-1:0]                    match_q;
  logic [TW-1:0]                    total_q, total_d;
  logic [TW-1:0]                    runs_q, runs_d;
  logic                             out_valid_q, out_valid_d;
  logic [JW-1:0]                    steps_out_q;
  logic [SW-1:0]                    start_out_q;
  logic [JW-1:0]                    length_out_q;
  logic [SW-1:0]                    added_out_q;

  logic                             ram_we;
  logic [SW-1:0]                    ram_waddr;
  logic [SW-1:0]                    ram_wdata;
  logic [SW-1:0]                    ram_rdata;

  logic [SW-1:0]                    added;
  logic [TW:0]                      total_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= bnas_pkg::NODE_CNT_W'(6);
      fanin_count_q <= bnas_pkg::FANIN_CNT_W'(3);
      wiring_low_q  <= '0;
      wiring_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bnas_pkg::cfg_reg_e'(cfg_index_i))
        bnas_pkg::CFG_NODE_COUNT:
          node_count_q <= cfg_data_i[bnas_pkg::NODE_CNT_W-1:0];
        bnas_pkg::CFG_FANIN_COUNT:
          fanin_count_q <= cfg_data_i[bnas_pkg::FANIN_CNT_W-1:0];
        bnas_pkg::CFG_WIRING_LOW:
          wiring_low_q <= cfg_data_i[bnas_pkg::WIRING_W-1:0];
        bnas_pkg::CFG_WIRING_HIGH:
          wiring_high_q <= cfg_data_i[bnas_pkg::WIRING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = bnas_pkg::NODE_CNT_W'(1);
    end else if (node_count_q > bnas_pkg::NODE_CNT_W'(bnas_pkg::NODES)) begin
      n_eff = bnas_pkg::NODE_CNT_W'(bnas_pkg::NODES);
    end else begin
      n_eff = node_count_q;
    end
    if (fanin_count_q == '0) begin
      k_eff = bnas_pkg::FANIN_CNT_W'(1);
    end else if (fanin_count_q > bnas_pkg::FANIN_CNT_W'(bnas_pkg::FANIN_MAX)) begin
      k_eff = bnas_pkg::FANIN_CNT_W'(bnas_pkg::FANIN_MAX);
    end else begin
      k_eff = fanin_count_q;
    end
    for (int i = 0; i < SW; i++) begin
      mask[i] = (i < int'(n_eff));
    end
  end

  assign start_masked = start_state_i & mask;
  assign nx     = bnas_pkg::next_state(state_q, n_eff, k_eff, {wiring_high_q, wiring_low_q});
  assign j_next = step_q + JW'(1);
  assign hit    = visited_q[nx];

  assign ram_we    = ctl_i.load | (ctl_i.step & ~hit);
  assign ram_waddr = ctl_i.load ? start_masked : nx;
  assign ram_wdata = ctl_i.load ? '0 : j_next[SW-1:0];

  bnas_ram #(
    .WIDTH(SW),
    .DEPTH(bnas_pkg::STORE_DEPTH)
  ) u_visit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(nx),
    .rdata_o(ram_rdata)
  );

  assign added     = SW'(step_q - JW'(1));
  assign total_sum = {1'b0, total_q} + (TW+1)'(added);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    visited_d   = visited_q;
    total_d     = total_q;
    runs_d      = runs_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (ctl_i.load) begin
      state_d                 = start_masked;
      step_d                  = '0;
      visited_d               = '0;
      visited_d[start_masked] = 1'b1;
    end
    if (ctl_i.step) begin
      state_d = nx;
      step_d  = j_next;
      if (!hit) begin
        visited_d[nx] = 1'b1;
      end
    end
    if (ctl_i.finish) begin
      out_valid_d = 1'b1;
      total_d     = total_sum[TW] ? '1 : total_sum[TW-1:0];
      runs_d      = (runs_q == '1) ? runs_q : runs_q + TW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      step_q      <= '0;
      visited_q   <= '0;
      total_q     <= '0;
      runs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      visited_q   <= visited_d;
      total_q     <= total_d;
      runs_q      <= runs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      match_q <= ram_rdata;
    end
    if (ctl_i.finish) begin
      steps_out_q  <= step_q;
      start_out_q  <= match_q;
      length_out_q <= step_q - {1'b0, match_q};
      added_out_q  <= added;
    end
  end

  assign stat_o.hit      = hit;
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign steps_to_repeat_o = steps_out_q;
  assign cycle_start_o     = start_out_q;
  assign cycle_length_o    = length_out_q;
  assign step_added_o      = added_out_q;
  assign total_steps_o     = total_q;
  assign run_count_o       = runs_q;

endmodule

// File: rtl/bnas_checker.sv
// Port-level assertions for the attractor search block and their binding.
module bnas_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [bnas_pkg::STEP_W-1:0]     steps_to_repeat_o,
  input logic [bnas_pkg::STATE_W-1:0]    cycle_start_o,
  input logic [bnas_pkg::STEP_W-1:0]     cycle_length_o,
  input logic [bnas_pkg::STATE_W-1:0]    step_added_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(steps_to_repeat_o)
      && $stable(cycle_start_o))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Block accepted a request while still busy.");

  a_length_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cycle_length_o == steps_to_repeat_o - {1'b0, cycle_start_o})
    else $error("Cycle length does not match repeat step and cycle start.");

  a_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, step_added_o} == steps_to_repeat_o - 9'd1)
    else $error("Added step count is not one less than the repeat step.");

  a_start_before_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, cycle_start_o} < steps_to_repeat_o)
    else $error("Cycle start is not before the repeat step.");

endmodule

bind boolean_network_attractor_search bnas_checker u_bnas_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .steps_to_repeat_o(steps_to_repeat_o),
  .cycle_start_o    (cycle_start_o),
  .cycle_length_o   (cycle_length_o),
  .step_added_o     (step_added_o)
);
